// ----- rtl/sust_pkg.sv -----
`timescale 1ns / 1ps

package sust_pkg;

	// Default table capacity and the fixed field widths of the streams.
	localparam int unsigned DEPTH_DEF = 32;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned FUNC_W    = 2;
	localparam int unsigned STATUS_W  = 3;

	// Request codes carried on the slave-side tuser.
	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT   = 2'd0,
		FN_DELETE   = 2'd1,
		FN_READ_FWD = 2'd2,
		FN_READ_REV = 2'd3
	} func_t;

	// Result codes carried on the master-side tuser.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    accept;
		logic    scan_run;
		logic    shift_start;
		logic    shift_run;
		logic    commit;
		logic    status_we;
		status_t status;
		logic    resp_load;
		logic    rd_start;
		logic    rd_emit;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		func_t func;
		logic  empty;
		logic  full;
		logic  scan_hit;
		logic  scan_dup;
		logic  scan_miss;
		logic  shift_done;
		logic  rd_last;
		logic  out_free;
	} sts_t;

endpackage

// ----- rtl/sorted_unique_set_table.sv -----
`timescale 1ns / 1ps
// Sorted table of distinct signed 32-bit values, kept largest first.
// Requests enter on the slave-side stream: s_tuser selects insert, delete,
// descending readout or ascending readout, and s_tdata carries the value.
// Results leave on the master-side stream: m_tuser is the status code,
// m_tdata the entry during a readout (zero otherwise), and m_tlast marks
// the final result of each request. Insert and delete give one result; a
// readout gives one result per entry, or a single empty result.
// One request is handled at a time; s_tready is high only while idle.
// Insert and delete first scan the entries through the single read port of
// the table memory, one entry per cycle, then move the entries behind the
// hit one place per cycle. A readout streams one entry per cycle when the
// receiver keeps up. A one-entry output register sits between the
// controller and the master side, so a stall holds the result; a readout
// pauses until it is taken, and an insert or delete waits with its result.
// Reset empties the table at once; the memory itself needs no clearing pass.
module sorted_unique_set_table #(
	parameter int unsigned DEPTH = sust_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sust_pkg::WORD_W-1:0]   s_tdata,  // [31:0] value
	input  logic [sust_pkg::FUNC_W-1:0]   s_tuser,  // [1:0] func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sust_pkg::WORD_W-1:0]   m_tdata,  // [31:0] item
	output logic [sust_pkg::STATUS_W-1:0] m_tuser,  // [2:0] status
	output logic                          m_tlast
);

	sust_pkg::cmd_t cmd;
	sust_pkg::sts_t sts;

	sust_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sust_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ----- rtl/sust_ram.sv -----
`timescale 1ns / 1ps

module sust_ram #(
	parameter int unsigned WIDTH = sust_pkg::WORD_W,
	parameter int unsigned DEPTH = sust_pkg::DEPTH_DEF,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; the read data holds when idle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/sust_ctrl.sv -----
`timescale 1ns / 1ps

module sust_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  sust_pkg::sts_t       sts,
	output sust_pkg::cmd_t       cmd
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_SCAN     = 6'b000100,
		S_SHIFT    = 6'b001000,
		S_RESP     = 6'b010000,
		S_RD_EMIT  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				priority if (sts.func == sust_pkg::FN_INSERT) begin
					state_d = S_SCAN;
				end else if (sts.func == sust_pkg::FN_DELETE && !sts.empty) begin
					state_d = S_SCAN;
				end else if (sts.empty) begin
					// Delete or readout on an empty table.
					cmd.status_we = 1'b1;
					cmd.status    = sust_pkg::ST_EMPTY;
					state_d       = S_RESP;
				end else begin
					cmd.rd_start = 1'b1;
					state_d      = S_RD_EMIT;
				end
			end
			S_SCAN: begin
				if (sts.func == sust_pkg::FN_INSERT) begin
					priority if (sts.scan_hit && sts.scan_dup) begin
						cmd.status_we = 1'b1;
						cmd.status    = sust_pkg::ST_DUP;
						state_d       = S_RESP;
					end else if ((sts.scan_hit || sts.scan_miss) && sts.full) begin
						cmd.status_we = 1'b1;
						cmd.status    = sust_pkg::ST_FULL;
						state_d       = S_RESP;
					end else if (sts.scan_hit || sts.scan_miss) begin
						cmd.shift_start = 1'b1;
						state_d         = S_SHIFT;
					end else begin
						cmd.scan_run = 1'b1;
					end
				end else begin
					priority if (sts.scan_hit) begin
						cmd.shift_start = 1'b1;
						state_d         = S_SHIFT;
					end else if (sts.scan_miss) begin
						cmd.status_we = 1'b1;
						cmd.status    = sust_pkg::ST_NOTFOUND;
						state_d       = S_RESP;
					end else begin
						cmd.scan_run = 1'b1;
					end
				end
			end
			S_SHIFT: begin
				if (sts.shift_done) begin
					cmd.commit    = 1'b1;
					cmd.status_we = 1'b1;
					cmd.status    = sust_pkg::ST_OK;
					state_d       = S_RESP;
				end else begin
					cmd.shift_run = 1'b1;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.resp_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_RD_EMIT: begin
				if (sts.out_free) begin
					cmd.rd_emit = 1'b1;
					if (sts.rd_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/sust_dp.sv -----
`timescale 1ns / 1ps

module sust_dp #(
	parameter int unsigned DEPTH = sust_pkg::DEPTH_DEF,
	localparam int unsigned AW   = $clog2(DEPTH),
	localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sust_pkg::cmd_t                  cmd,
	output sust_pkg::sts_t                  sts,
	input  logic [sust_pkg::FUNC_W-1:0]     s_tuser,
	input  logic [sust_pkg::WORD_W-1:0]     s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sust_pkg::WORD_W-1:0]     m_tdata,
	output logic [sust_pkg::STATUS_W-1:0]   m_tuser,
	output logic                            m_tlast
);

	// Request registers.
	sust_pkg::func_t                    func_q;
	logic signed [sust_pkg::WORD_W-1:0] value_q;
	sust_pkg::status_t                  status_q;

	// Table occupancy and walk counters.
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] cmp_idx_s1;
	logic          scan_vld_s1;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] sh_q;
	logic          wr_pend_s1;
	logic [AW-1:0] wr_addr_s1;

	// Output register.
	logic                            o_valid_q;
	sust_pkg::status_t               o_status_q;
	logic [sust_pkg::WORD_W-1:0]     o_item_q;
	logic                            o_last_q;

	// Memory port signals.
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [sust_pkg::WORD_W-1:0]  ram_wdata;
	logic                         ram_re;
	logic [CW-1:0]                raddr_w;
	logic [sust_pkg::WORD_W-1:0]  ram_rdata;

	// Derived values.
	logic          is_ins;
	logic          fwd;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] idx_next;
	logic [CW-1:0] rev_addr;
	logic [CW-1:0] rev_next;
	logic [CW-1:0] sh_m1;
	logic [CW-1:0] sh_p1;
	logic          scan_more;
	logic          ins_more;
	logic          del_more;
	logic          rd_last;
	logic          out_free;
	logic          rd_le;
	logic          rd_eq;

	assign is_ins    = (func_q == sust_pkg::FN_INSERT);
	assign fwd       = (func_q == sust_pkg::FN_READ_FWD);
	assign cnt_m1    = count_q - CW'(1);
	assign idx_next  = rd_idx_q + CW'(1);
	assign rev_addr  = cnt_m1 - rd_idx_q;
	assign rev_next  = rev_addr - CW'(1);
	assign sh_m1     = sh_q - CW'(1);
	assign sh_p1     = cmp_idx_s1 + CW'(1);
	assign scan_more = (rd_idx_q < count_q);
	assign ins_more  = (sh_q > pos_q);
	assign del_more  = (sh_q < count_q);
	assign rd_last   = (rd_idx_q == cnt_m1);
	assign out_free  = !o_valid_q || m_tready;
	assign rd_le     = ($signed(ram_rdata) <= value_q);
	assign rd_eq     = ($signed(ram_rdata) == value_q);

	// Status toward the controller.
	always_comb begin
		sts            = '0;
		sts.func       = func_q;
		sts.empty      = (count_q == '0);
		sts.full       = (count_q == CW'(DEPTH));
		sts.scan_hit   = scan_vld_s1 && (is_ins ? rd_le : rd_eq);
		sts.scan_dup   = rd_eq;
		sts.scan_miss  = !scan_vld_s1 && !scan_more;
		sts.shift_done = !wr_pend_s1 && (is_ins ? !ins_more : !del_more);
		sts.rd_last    = rd_last;
		sts.out_free   = out_free;
	end

	// Read port: scan, entry move and readout share the one read address.
	always_comb begin
		ram_re  = 1'b0;
		raddr_w = rd_idx_q;
		priority if (cmd.scan_run && scan_more) begin
			ram_re  = 1'b1;
			raddr_w = rd_idx_q;
		end else if (cmd.shift_run && is_ins && ins_more) begin
			ram_re  = 1'b1;
			raddr_w = sh_m1;
		end else if (cmd.shift_run && !is_ins && del_more) begin
			ram_re  = 1'b1;
			raddr_w = sh_q;
		end else if (cmd.rd_start) begin
			ram_re  = 1'b1;
			raddr_w = fwd ? '0 : cnt_m1;
		end else if (cmd.rd_emit && !rd_last) begin
			ram_re  = 1'b1;
			raddr_w = fwd ? idx_next : rev_next;
		end else begin
			ram_re = 1'b0;
		end
	end

	// Write port: moved entries first, then the new value of an insert.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_addr_s1;
		ram_wdata = ram_rdata;
		priority if (wr_pend_s1) begin
			ram_we = 1'b1;
		end else if (cmd.commit && is_ins) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q[AW-1:0];
			ram_wdata = value_q;
		end else begin
			ram_we = 1'b0;
		end
	end

	sust_ram #(
		.WIDTH(sust_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(raddr_w[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_idx_q    <= '0;
			scan_vld_s1 <= 1'b0;
			pos_q       <= '0;
			sh_q        <= '0;
			wr_pend_s1  <= 1'b0;
			o_valid_q   <= 1'b0;
		end else begin
			// Scan and readout index.
			if (cmd.accept) begin
				rd_idx_q    <= '0;
				scan_vld_s1 <= 1'b0;
			end else if (cmd.scan_run) begin
				scan_vld_s1 <= scan_more;
				if (scan_more) begin
					rd_idx_q <= idx_next;
				end
			end else if (cmd.rd_start) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_emit && !rd_last) begin
				rd_idx_q <= idx_next;
			end

			// Entry move: inserts walk down from the tail, deletes walk up to it.
			priority if (cmd.shift_start) begin
				wr_pend_s1 <= 1'b0;
				if (is_ins) begin
					pos_q <= scan_vld_s1 ? cmp_idx_s1 : count_q;
					sh_q  <= count_q;
				end else begin
					pos_q <= cmp_idx_s1;
					sh_q  <= sh_p1;
				end
			end else if (cmd.shift_run) begin
				if (is_ins) begin
					wr_pend_s1 <= ins_more;
					if (ins_more) begin
						sh_q <= sh_m1;
					end
				end else begin
					wr_pend_s1 <= del_more;
					if (del_more) begin
						sh_q <= sh_q + CW'(1);
					end
				end
			end else begin
				wr_pend_s1 <= 1'b0;
			end

			// Occupancy.
			if (cmd.commit) begin
				count_q <= is_ins ? (count_q + CW'(1)) : cnt_m1;
			end

			// Output valid.
			if (cmd.resp_load || cmd.rd_emit) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= sust_pkg::func_t'(s_tuser);
			value_q <= s_tdata;
		end
		if (cmd.scan_run) begin
			cmp_idx_s1 <= rd_idx_q;
		end
		if (cmd.shift_run) begin
			wr_addr_s1 <= is_ins ? sh_q[AW-1:0] : sh_m1[AW-1:0];
		end
		if (cmd.status_we) begin
			status_q <= cmd.status;
		end
		if (cmd.resp_load) begin
			o_status_q <= status_q;
			o_item_q   <= '0;
			o_last_q   <= 1'b1;
		end else if (cmd.rd_emit) begin
			o_status_q <= sust_pkg::ST_OK;
			o_item_q   <= ram_rdata;
			o_last_q   <= rd_last;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = o_item_q;
	assign m_tuser  = o_status_q;
	assign m_tlast  = o_last_q;

endmodule
